>>> rtl/core/agd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// agd_pkg
// Types and constants shared by the audio glitch detector modules.
// ----------------------------------------------------------------------------
package agd_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int CH_W         = 3;
	localparam int IDX_W        = 16;
	localparam int POS_W        = 15;
	localparam int Q_W          = 24;
	localparam int CNT_W        = 16;
	localparam int LIM_W        = 4;

	localparam logic [POS_W-1:0] POS_LIMIT = 15'd32767;
	localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

	// Configuration register indexes
	localparam logic [2:0] REG_ENABLE       = 3'd0;
	localparam logic [2:0] REG_SOFT_THRESH  = 3'd1;
	localparam logic [2:0] REG_HARD_THRESH  = 3'd2;
	localparam logic [2:0] REG_REPORT_THR   = 3'd3;
	localparam logic [2:0] REG_CRACKLE_JMPS = 3'd4;
	localparam logic [2:0] REG_CRACKLE_MIN  = 3'd5;
	localparam logic [2:0] REG_CHANNELS     = 3'd6;

	// Event kind bits
	localparam int KIND_NAN     = 0;
	localparam int KIND_HARD    = 1;
	localparam int KIND_CRACKLE = 2;

	typedef struct packed {
		logic             detector_enable;
		logic [Q_W-1:0]   soft_jump_threshold;
		logic [Q_W-1:0]   hard_jump_threshold;
		logic [Q_W-1:0]   report_jump_threshold;
		logic [CNT_W-1:0] crackle_min_jumps;
		logic [Q_W-1:0]   crackle_jump_minimum;
		logic [LIM_W-1:0] channels_in_use;
	} cfg_t;

	// One converted sample on its way to the tracker
	typedef struct packed {
		logic                   en;
		logic                   active;
		logic                   nonfinite;
		logic [CH_W-1:0]        ch;
		logic [POS_W-1:0]       pos;
		logic signed [Q_W-1:0]  value;
		logic                   last;
	} conv_item_t;

	// Per-block accumulators, also the snapshot handed to classification
	typedef struct packed {
		logic [CNT_W-1:0]       nan_total;
		logic [CNT_W-1:0]       jump_total;
		logic [Q_W-1:0]         peak_level;
		logic [Q_W-1:0]         largest_jump;
		logic                   nan_valid;
		logic [CH_W-1:0]        nan_ch;
		logic [POS_W-1:0]       nan_smp;
		logic                   hard_valid;
		logic [CH_W-1:0]        hard_ch;
		logic [POS_W-1:0]       hard_smp;
		logic signed [Q_W-1:0]  hard_prev;
		logic signed [Q_W-1:0]  hard_curr;
	} block_acc_t;

endpackage
`default_nettype wire

>>> rtl/core/agd_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// agd_convert
// Input register, float to Q3.20 conversion and channel gating.
// ----------------------------------------------------------------------------
module agd_convert (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              advance,
	input  wire                              in_valid,
	input  wire [agd_pkg::CH_W-1:0]          in_channel,
	input  wire [agd_pkg::IDX_W-1:0]         in_index,
	input  wire [31:0]                       in_bits,
	input  wire                              in_last,
	input  wire agd_pkg::cfg_t               cfg,
	output logic                             item_valid_s2,
	output agd_pkg::conv_item_t              item_s2
);

	logic                        valid_s1;
	logic [agd_pkg::CH_W-1:0]    ch_s1;
	logic [agd_pkg::IDX_W-1:0]   idx_s1;
	logic [31:0]                 bits_s1;
	logic                        last_s1;

	logic [7:0]                  exp_raw;
	logic [7:0]                  exp_eff;
	logic [23:0]                 mant;
	logic [7:0]                  shift;
	logic [4:0]                  shift_m1;
	logic [24:0]                 shifted;
	logic [24:0]                 mag;
	logic [23:0]                 mag24;
	logic signed [agd_pkg::Q_W-1:0] value;
	logic [agd_pkg::LIM_W-1:0]   limit;
	logic                        in_range;
	logic [agd_pkg::POS_W-1:0]   pos;
	agd_pkg::conv_item_t         item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ch_s1   <= in_channel;
			idx_s1  <= in_index;
			bits_s1 <= in_bits;
			last_s1 <= in_last;
		end
	end

	always_comb begin
		exp_raw  = bits_s1[30:23];
		mant     = {exp_raw != 8'd0, bits_s1[22:0]};
		exp_eff  = (exp_raw == 8'd0) ? 8'd1 : exp_raw;
		shift    = 8'd130 - exp_eff;
		shift_m1 = shift[4:0] - 5'd1;
		// round half away from zero: shift to one extra bit, add one, drop it
		shifted  = ({1'b0, mant} >> shift_m1) + 25'd1;
		if (exp_eff >= 8'd130) begin
			mag = 25'h800000;
		end else if (shift > 8'd25) begin
			mag = 25'd0;
		end else begin
			mag = {1'b0, shifted[24:1]};
		end
		mag24 = mag[23:0];
		if (bits_s1[31]) begin
			value = 24'd0 - mag24;
		end else begin
			value = mag24[23] ? 24'h7FFFFF : mag24;
		end

		limit = (cfg.channels_in_use > agd_pkg::LIM_W'(agd_pkg::MAX_CHANNELS))
			? agd_pkg::LIM_W'(agd_pkg::MAX_CHANNELS) : cfg.channels_in_use;
		in_range = ({1'b0, ch_s1} < limit);
		pos = (idx_s1 > {1'b0, agd_pkg::POS_LIMIT}) ? agd_pkg::POS_LIMIT
			: idx_s1[agd_pkg::POS_W-1:0];

		item.en        = cfg.detector_enable;
		item.active    = cfg.detector_enable & in_range;
		item.nonfinite = (exp_raw == 8'hFF);
		item.ch        = ch_s1;
		item.pos       = pos;
		item.value     = value;
		item.last      = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s2 <= 1'b0;
		end else if (advance) begin
			item_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2 <= item;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/agd_track.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// agd_track
// Per-channel last good sample, block accumulators and end-of-block snapshot.
// ----------------------------------------------------------------------------
module agd_track (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              advance,
	input  wire                              item_valid_s2,
	input  wire agd_pkg::conv_item_t         item_s2,
	input  wire agd_pkg::cfg_t               cfg,
	output logic                             snap_valid_s3,
	output agd_pkg::block_acc_t              snap_s3
);

	logic signed [agd_pkg::Q_W-1:0] prev_q [agd_pkg::MAX_CHANNELS];
	agd_pkg::block_acc_t            acc_q;
	agd_pkg::block_acc_t            acc_next;

	logic signed [agd_pkg::Q_W-1:0] p;
	logic signed [agd_pkg::Q_W:0]   diff;
	logic [agd_pkg::Q_W:0]          diff_abs;
	logic [agd_pkg::Q_W-1:0]        delta;
	logic [agd_pkg::Q_W-1:0]        mag;
	logic                           take;
	logic                           good;

	assign take = advance & item_valid_s2 & item_s2.en;
	assign good = item_s2.active & ~item_s2.nonfinite;

	always_comb begin
		p        = prev_q[item_s2.ch];
		diff     = {item_s2.value[agd_pkg::Q_W-1], item_s2.value} - {p[agd_pkg::Q_W-1], p};
		diff_abs = diff[agd_pkg::Q_W] ? (agd_pkg::Q_W+1)'(-diff) : diff;
		delta    = diff_abs[agd_pkg::Q_W-1:0];
		mag      = item_s2.value[agd_pkg::Q_W-1] ? agd_pkg::Q_W'(-item_s2.value)
			: item_s2.value;

		acc_next = acc_q;
		if (item_s2.active && item_s2.nonfinite) begin
			if (acc_q.nan_total != agd_pkg::CNT_MAX) begin
				acc_next.nan_total = acc_q.nan_total + 16'd1;
			end
			if (!acc_q.nan_valid) begin
				acc_next.nan_valid = 1'b1;
				acc_next.nan_ch    = item_s2.ch;
				acc_next.nan_smp   = item_s2.pos;
			end
		end
		if (good) begin
			if (mag > acc_q.peak_level) begin
				acc_next.peak_level = mag;
			end
			if (delta >= cfg.soft_jump_threshold) begin
				if (acc_q.jump_total != agd_pkg::CNT_MAX) begin
					acc_next.jump_total = acc_q.jump_total + 16'd1;
				end
				if (delta > acc_q.largest_jump) begin
					acc_next.largest_jump = delta;
				end
				if (delta >= cfg.hard_jump_threshold && !acc_q.hard_valid) begin
					acc_next.hard_valid = 1'b1;
					acc_next.hard_ch    = item_s2.ch;
					acc_next.hard_smp   = item_s2.pos;
					acc_next.hard_prev  = p;
					acc_next.hard_curr  = item_s2.value;
				end
			end
		end
	end

	// non-finite samples leave the last good value in place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < agd_pkg::MAX_CHANNELS; i++) begin
				prev_q[i] <= '0;
			end
		end else if (take && good) begin
			prev_q[item_s2.ch] <= item_s2.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (take) begin
			acc_q <= item_s2.last ? '0 : acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s3 <= 1'b0;
		end else if (advance) begin
			snap_valid_s3 <= item_valid_s2 & item_s2.en & item_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			snap_s3 <= acc_next;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/agd_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// agd_classify
// Block classification, event field selection and output register.
// ----------------------------------------------------------------------------
module agd_classify (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              snap_valid_s3,
	input  wire agd_pkg::block_acc_t         snap_s3,
	input  wire agd_pkg::cfg_t               cfg,
	output logic                             advance,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [2:0]                       out_kind,
	output logic [151:0]                     out_data
);

	logic                           has_nan;
	logic                           has_hard;
	logic                           has_crackle;
	logic [2:0]                     kind;
	logic                           pos_valid;
	logic [agd_pkg::CH_W-1:0]       ev_ch;
	logic [agd_pkg::POS_W-1:0]      ev_smp;
	logic signed [agd_pkg::Q_W-1:0] j_prev;
	logic signed [agd_pkg::Q_W-1:0] j_curr;
	logic                           stall;

	// only a finished block blocked behind a waiting result holds the pipe
	assign stall   = snap_valid_s3 & out_valid & ~out_ready;
	assign advance = ~stall;

	always_comb begin
		has_nan     = snap_s3.nan_total != '0;
		has_hard    = snap_s3.hard_valid
			&& (snap_s3.largest_jump >= cfg.report_jump_threshold);
		has_crackle = (snap_s3.jump_total >= cfg.crackle_min_jumps)
			&& (snap_s3.largest_jump >= cfg.crackle_jump_minimum);
		kind = '0;
		kind[agd_pkg::KIND_NAN]     = has_nan;
		kind[agd_pkg::KIND_HARD]    = has_hard;
		kind[agd_pkg::KIND_CRACKLE] = has_crackle;

		priority if (has_nan && snap_s3.nan_valid) begin
			pos_valid = 1'b1;
			ev_ch     = snap_s3.nan_ch;
			ev_smp    = snap_s3.nan_smp;
			j_prev    = '0;
			j_curr    = '0;
		end else if (snap_s3.hard_valid) begin
			pos_valid = 1'b1;
			ev_ch     = snap_s3.hard_ch;
			ev_smp    = snap_s3.hard_smp;
			j_prev    = snap_s3.hard_prev;
			j_curr    = snap_s3.hard_curr;
		end else begin
			pos_valid = 1'b0;
			ev_ch     = '0;
			ev_smp    = '0;
			j_prev    = '0;
			j_curr    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (snap_valid_s3 && advance && kind != 3'd0) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// drop blocks with no flag set
	always_ff @(posedge clk) begin
		if (snap_valid_s3 && advance && kind != 3'd0) begin
			out_kind <= kind;
			out_data <= {5'd0, j_curr, j_prev, ev_smp, ev_ch, pos_valid,
				snap_s3.peak_level, snap_s3.largest_jump,
				snap_s3.jump_total, snap_s3.nan_total};
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/audio_glitch_detector_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_glitch_detector_top
// Audio glitch detector: tracks non-finite samples and sample-to-sample jumps
// over a block and reports one event per flagged block.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one float sample per item, channel-major within a block;
//   s_axis_tlast marks the final sample of a block.
//   m_axis carries one event item per block that had a non-finite sample, a
//   hard jump or crackle; unflagged blocks produce nothing.
//   cfg writes one register per item (index 0..6); always ready. Write only
//   while no block is in flight.
// Timing:
//   One sample per cycle while s_axis is not stalled. After the last sample of
//   its block is accepted, its event passes through the input register, the
//   conversion stage, the tracking stage and classification into the output register.
//   Channel history and block accumulators are registered as each item is taken.
// Reset and stall:
//   Reset clears channel history, accumulators and pipeline valids and loads
//   the register defaults. While an event waits on m_axis_tready the block
//   keeps taking samples; it stalls s_axis only when a second finished block
//   reaches classification before the first event is taken.
// ----------------------------------------------------------------------------
module audio_glitch_detector_top (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [55:0]  s_axis_tdata,  // channel[2:0], sample_index[18:3], sample_bits[50:19]
	input  wire          s_axis_tlast,  // last_of_block
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [151:0] m_axis_tdata,  // nan_count[15:0], jump_count[31:16],
	                                    // max_jump[55:32], peak[79:56],
	                                    // position_valid[80], event_channel[83:81],
	                                    // event_sample[98:84], jump_prev[122:99],
	                                    // jump_curr[146:123]
	output logic [2:0]   m_axis_tuser,  // kind[2:0]
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [2:0]   cfg_index,
	input  wire  [23:0]  cfg_data
);

	agd_pkg::cfg_t       cfg_q;
	logic                advance;
	logic                item_valid_s2;
	agd_pkg::conv_item_t item_s2;
	logic                snap_valid_s3;
	agd_pkg::block_acc_t snap_s3;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detector_enable       <= 1'b1;
			cfg_q.soft_jump_threshold   <= 24'd262144;
			cfg_q.hard_jump_threshold   <= 24'd524288;
			cfg_q.report_jump_threshold <= 24'd524288;
			cfg_q.crackle_min_jumps     <= 16'd4;
			cfg_q.crackle_jump_minimum  <= 24'd104858;
			cfg_q.channels_in_use       <= 4'd2;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				agd_pkg::REG_ENABLE:       cfg_q.detector_enable       <= cfg_data[0];
				agd_pkg::REG_SOFT_THRESH:  cfg_q.soft_jump_threshold   <= cfg_data;
				agd_pkg::REG_HARD_THRESH:  cfg_q.hard_jump_threshold   <= cfg_data;
				agd_pkg::REG_REPORT_THR:   cfg_q.report_jump_threshold <= cfg_data;
				agd_pkg::REG_CRACKLE_JMPS: cfg_q.crackle_min_jumps     <= cfg_data[15:0];
				agd_pkg::REG_CRACKLE_MIN:  cfg_q.crackle_jump_minimum  <= cfg_data;
				agd_pkg::REG_CHANNELS:     cfg_q.channels_in_use       <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	agd_convert u_convert (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.in_valid      (s_axis_tvalid),
		.in_channel    (s_axis_tdata[2:0]),
		.in_index      (s_axis_tdata[18:3]),
		.in_bits       (s_axis_tdata[50:19]),
		.in_last       (s_axis_tlast),
		.cfg           (cfg_q),
		.item_valid_s2 (item_valid_s2),
		.item_s2       (item_s2)
	);

	agd_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.item_valid_s2 (item_valid_s2),
		.item_s2       (item_s2),
		.cfg           (cfg_q),
		.snap_valid_s3 (snap_valid_s3),
		.snap_s3       (snap_s3)
	);

	agd_classify u_classify (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid_s3 (snap_valid_s3),
		.snap_s3       (snap_s3),
		.cfg           (cfg_q),
		.advance       (advance),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_kind      (m_axis_tuser),
		.out_data      (m_axis_tdata)
	);

endmodule
`default_nettype wire

>>> test/audio_glitch_detector_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_glitch_detector_top_tb
// Streams float samples into the glitch detector and checks every block event
// it reports against a cycle-free predictor of the detector. A short table of
// hand-picked samples runs first, then randomized blocks under a range of
// register settings and handshake pressure.
// ----------------------------------------------------------------------------
module audio_glitch_detector_top_tb;
	import agd_pkg::*;

	typedef struct packed {
		logic [CH_W-1:0]  channel;
		logic [IDX_W-1:0] idx;
		logic [31:0]      bits;
		logic             last;
	} sample_t;

	typedef struct packed {
		logic [2:0]             kind;
		logic [CNT_W-1:0]       nan_count;
		logic [CNT_W-1:0]       jump_count;
		logic [Q_W-1:0]         max_jump;
		logic [Q_W-1:0]         peak;
		logic                   pos_valid;
		logic [CH_W-1:0]        ev_ch;
		logic [POS_W-1:0]       ev_smp;
		logic signed [Q_W-1:0]  jprev;
		logic signed [Q_W-1:0]  jcurr;
	} glitch_event_t;

	typedef struct packed {
		sample_t       s;
		logic          fixed;
		glitch_event_t want;
	} directed_row_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [55:0]  s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [151:0] m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [23:0]  cfg_data;

	audio_glitch_detector_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// Detector copy: registers, channel history and block accumulators
	cfg_t                  det_cfg;
	logic signed [Q_W-1:0] last_good [MAX_CHANNELS];
	logic [CNT_W-1:0]      nan_seen;
	logic [CNT_W-1:0]      jumps_seen;
	logic [Q_W-1:0]        peak_level;
	logic [Q_W-1:0]        largest_step;
	logic                  nan_pos_ok;
	logic [CH_W-1:0]       nan_pos_ch;
	logic [POS_W-1:0]      nan_pos_smp;
	logic                  hard_pos_ok;
	logic [CH_W-1:0]       hard_pos_ch;
	logic [POS_W-1:0]      hard_pos_smp;
	logic signed [Q_W-1:0] hard_before;
	logic signed [Q_W-1:0] hard_after;

	glitch_event_t expected_events [$];
	directed_row_t directed_rows [$];
	int            mismatches = 0;
	int            send_idle_pct = 0;
	int            stall_pct = 0;

	function automatic logic signed [Q_W-1:0] float_to_q(input logic [31:0] f);
		int unsigned ex, mant, mag, sh, negated;
		ex = {24'd0, f[30:23]};
		mant = {9'd0, f[22:0]};
		if (ex != 0) begin
			mant = mant | 32'h0080_0000;
		end else begin
			ex = 1;
		end
		if (ex >= 130) begin
			mag = 32'h0080_0000;
		end else begin
			sh = 130 - ex;
			if (sh > 25)
				mag = 0;
			else
				mag = (mant + (32'd1 << (sh - 1))) >> sh;
		end
		if (f[31]) begin
			if (mag > 32'h0080_0000)
				mag = 32'h0080_0000;
			negated = 0 - mag;
			return negated[Q_W-1:0];
		end
		if (mag > 32'h007F_FFFF)
			mag = 32'h007F_FFFF;
		return mag[Q_W-1:0];
	endfunction

	function automatic void clear_block_state();
		nan_seen = '0;
		jumps_seen = '0;
		peak_level = '0;
		largest_step = '0;
		nan_pos_ok = 1'b0;
		nan_pos_ch = '0;
		nan_pos_smp = '0;
		hard_pos_ok = 1'b0;
		hard_pos_ch = '0;
		hard_pos_smp = '0;
		hard_before = '0;
		hard_after = '0;
	endfunction

	// Advance the detector copy by one sample; returns 1 when the block emits
	function automatic bit predict_event(input sample_t s, output glitch_event_t ev);
		int unsigned    lim, mag, step_mag;
		int             vi, pi, di;
		logic [POS_W-1:0] pos;
		bit             has_nan, has_hard, has_crackle;
		ev = '0;
		if (!det_cfg.detector_enable)
			return 0;
		lim = {28'd0, det_cfg.channels_in_use};
		if (lim > MAX_CHANNELS)
			lim = MAX_CHANNELS;
		pos = (s.idx > POS_LIMIT) ? POS_LIMIT : s.idx[POS_W-1:0];
		if (32'(s.channel) < lim) begin
			if (s.bits[30:23] == 8'hFF) begin
				if (nan_seen != CNT_MAX)
					nan_seen = nan_seen + 1'b1;
				if (!nan_pos_ok) begin
					nan_pos_ok = 1'b1;
					nan_pos_ch = s.channel;
					nan_pos_smp = pos;
				end
			end else begin
				vi = int'(float_to_q(s.bits));
				pi = int'(last_good[s.channel]);
				di = vi - pi;
				mag = (vi < 0) ? -vi : vi;
				step_mag = (di < 0) ? -di : di;
				if (mag > 32'(peak_level))
					peak_level = mag[Q_W-1:0];
				if (step_mag >= 32'(det_cfg.soft_jump_threshold)) begin
					if (jumps_seen != CNT_MAX)
						jumps_seen = jumps_seen + 1'b1;
					if (step_mag > 32'(largest_step))
						largest_step = step_mag[Q_W-1:0];
					if (step_mag >= 32'(det_cfg.hard_jump_threshold) && !hard_pos_ok) begin
						hard_pos_ok = 1'b1;
						hard_pos_ch = s.channel;
						hard_pos_smp = pos;
						hard_before = pi[Q_W-1:0];
						hard_after = vi[Q_W-1:0];
					end
				end
				last_good[s.channel] = vi[Q_W-1:0];
			end
		end
		if (!s.last)
			return 0;
		has_nan = (nan_seen != '0);
		has_hard = hard_pos_ok && (largest_step >= det_cfg.report_jump_threshold);
		has_crackle = (jumps_seen >= det_cfg.crackle_min_jumps) &&
			(largest_step >= det_cfg.crackle_jump_minimum);
		if (!has_nan && !has_hard && !has_crackle) begin
			clear_block_state();
			return 0;
		end
		ev.kind[KIND_NAN] = has_nan;
		ev.kind[KIND_HARD] = has_hard;
		ev.kind[KIND_CRACKLE] = has_crackle;
		ev.nan_count = nan_seen;
		ev.jump_count = jumps_seen;
		ev.max_jump = largest_step;
		ev.peak = peak_level;
		if (has_nan && nan_pos_ok) begin
			ev.pos_valid = 1'b1;
			ev.ev_ch = nan_pos_ch;
			ev.ev_smp = nan_pos_smp;
		end else if (hard_pos_ok) begin
			ev.pos_valid = 1'b1;
			ev.ev_ch = hard_pos_ch;
			ev.ev_smp = hard_pos_smp;
			ev.jprev = hard_before;
			ev.jcurr = hard_after;
		end
		clear_block_state();
		return 1;
	endfunction

	function automatic void add_row(input sample_t s, input bit fixed, input glitch_event_t want);
		directed_row_t r;
		r.s = s;
		r.fixed = fixed;
		r.want = want;
		directed_rows.push_back(r);
	endfunction

	function automatic logic [Q_W-1:0] random_threshold();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return Q_W'($urandom);
			default: return Q_W'($urandom_range(0, 1 << 21));
		endcase
	endfunction

	function automatic logic [31:0] random_sample_bits();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return {1'($urandom), 8'hFF, ($urandom_range(0, 1) != 0) ? 23'($urandom) : 23'd0};
		if (r < 8)
			return {1'($urandom), 8'h00, ($urandom_range(0, 1) != 0) ? 23'($urandom) : 23'd0};
		if (r < 12)
			return {1'($urandom), 8'($urandom_range(130, 254)), 23'($urandom)};
		return {1'($urandom), 8'($urandom_range(118, 129)), 23'($urandom)};
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_sample(input sample_t s, input bit fixed, input glitch_event_t want);
		glitch_event_t ev;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, s.bits, s.idx, s.channel};
		s_axis_tlast <= s.last;
		do @(posedge clk); while (!s_axis_tready);
		if (predict_event(s, ev))
			expected_events.push_back(fixed ? want : ev);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ENABLE:       det_cfg.detector_enable = data[0];
			REG_SOFT_THRESH:  det_cfg.soft_jump_threshold = data;
			REG_HARD_THRESH:  det_cfg.hard_jump_threshold = data;
			REG_REPORT_THR:   det_cfg.report_jump_threshold = data;
			REG_CRACKLE_JMPS: det_cfg.crackle_min_jumps = data[CNT_W-1:0];
			REG_CRACKLE_MIN:  det_cfg.crackle_jump_minimum = data;
			REG_CHANNELS:     det_cfg.channels_in_use = data[LIM_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_settings(input cfg_t c);
		write_reg(REG_ENABLE, {23'd0, c.detector_enable});
		write_reg(REG_SOFT_THRESH, c.soft_jump_threshold);
		write_reg(REG_HARD_THRESH, c.hard_jump_threshold);
		write_reg(REG_REPORT_THR, c.report_jump_threshold);
		write_reg(REG_CRACKLE_JMPS, {8'd0, c.crackle_min_jumps});
		write_reg(REG_CRACKLE_MIN, c.crackle_jump_minimum);
		write_reg(REG_CHANNELS, {20'd0, c.channels_in_use});
		cfg_valid <= 1'b0;
	endtask

	// Hold until every expected event is out and the pipeline has emptied
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	// Mostly channel-major blocks with random content; some noise and cut-off blocks
	task automatic stream_blocks(input int target);
		int            sent, nch, len, base;
		bit            cut;
		sample_t       s;
		glitch_event_t none;
		sent = 0;
		none = '0;
		while (sent < target) begin
			if ($urandom_range(0, 9) == 0) begin
				s.channel = CH_W'($urandom);
				s.idx = IDX_W'($urandom);
				s.bits = $urandom;
				s.last = ($urandom_range(0, 3) == 0);
				send_sample(s, 1'b0, none);
				sent++;
			end else begin
				nch = $urandom_range(1, MAX_CHANNELS);
				len = $urandom_range(1, 6);
				base = ($urandom_range(0, 4) == 0) ? $urandom_range(32760, 65535 - len)
					: $urandom_range(0, 200);
				cut = ($urandom_range(0, 7) == 0);
				for (int c = 0; c < nch; c++) begin
					for (int k = 0; k < len; k++) begin
						s.channel = CH_W'(c);
						s.idx = IDX_W'(base + k);
						s.bits = random_sample_bits();
						s.last = !cut && (c == nch - 1) && (k == len - 1);
						send_sample(s, 1'b0, none);
						sent++;
					end
				end
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk) begin : take_event
		glitch_event_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.nan_count = m_axis_tdata[15:0];
			got.jump_count = m_axis_tdata[31:16];
			got.max_jump = m_axis_tdata[55:32];
			got.peak = m_axis_tdata[79:56];
			got.pos_valid = m_axis_tdata[80];
			got.ev_ch = m_axis_tdata[83:81];
			got.ev_smp = m_axis_tdata[98:84];
			got.jprev = m_axis_tdata[122:99];
			got.jcurr = m_axis_tdata[146:123];
			if (expected_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected event kind %0h", $time, got.kind);
			end else begin
				want = expected_events.pop_front();
				check_field("kind", want.kind, got.kind);
				check_field("nan_count", want.nan_count, got.nan_count);
				check_field("jump_count", want.jump_count, got.jump_count);
				check_field("max_jump", want.max_jump, got.max_jump);
				check_field("peak", want.peak, got.peak);
				check_field("position_valid", want.pos_valid, got.pos_valid);
				check_field("event_channel", want.ev_ch, got.ev_ch);
				check_field("event_sample", want.ev_smp, got.ev_smp);
				check_field("jump_prev", want.jprev, got.jprev);
				check_field("jump_curr", want.jcurr, got.jcurr);
			end
		end
	end

	initial begin
		#8_000_000;
		$display("audio_glitch_detector_top_tb NOT OK");
		$finish;
	end

	initial begin
		cfg_t          c;
		glitch_event_t none;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		none = '0;
		det_cfg = {1'b1, 24'd262144, 24'd524288, 24'd524288, 16'd4, 24'd104858, 4'd2};
		foreach (last_good[i])
			last_good[i] = '0;
		clear_block_state();

		// Rows: sample fields, then whether the event is typed in, then that event
		add_row({3'd0, 16'd0, 32'h7FC0_0000, 1'b1}, 1'b1,
			{3'd1, 16'd1, 16'd0, 24'd0, 24'd0, 1'b1, 3'd0, 15'd0, 24'd0, 24'd0});
		add_row({3'd1, 16'd65535, 32'h7F80_0000, 1'b1}, 1'b1,
			{3'd1, 16'd1, 16'd0, 24'd0, 24'd0, 1'b1, 3'd1, 15'd32767, 24'd0, 24'd0});
		add_row({3'd0, 16'd1, 32'h3F80_0000, 1'b0}, 1'b0, none);
		add_row({3'd1, 16'd1, 32'hC100_0000, 1'b1}, 1'b1,
			{3'd2, 16'd0, 16'd2, 24'h800000, 24'h800000, 1'b1, 3'd0, 15'd1, 24'd0,
			24'd1048576});
		add_row({3'd0, 16'd2, 32'h7F7F_FFFF, 1'b0}, 1'b0, none);
		add_row({3'd1, 16'd2, 32'h8000_0000, 1'b0}, 1'b0, none);
		add_row({3'd0, 16'd3, 32'h3500_0000, 1'b0}, 1'b0, none);
		add_row({3'd1, 16'd3, 32'hB500_0000, 1'b0}, 1'b0, none);
		add_row({3'd0, 16'd4, 32'h0000_0001, 1'b0}, 1'b0, none);
		add_row({3'd2, 16'd4, 32'hFFFF_FFFF, 1'b1}, 1'b0, none);
		add_row({3'd0, 16'd5, 32'h3E99_999A, 1'b0}, 1'b0, none);
		add_row({3'd0, 16'd6, 32'h0000_0000, 1'b0}, 1'b0, none);
		add_row({3'd0, 16'd7, 32'h3E99_999A, 1'b0}, 1'b0, none);
		add_row({3'd0, 16'd8, 32'h0000_0000, 1'b1}, 1'b1,
			{3'd4, 16'd0, 16'd4, 24'd314573, 24'd314573, 1'b0, 3'd0, 15'd0, 24'd0, 24'd0});
		add_row({3'd1, 16'd9, 32'h3E80_0000, 1'b1}, 1'b0, none);
		add_row({3'd1, 16'd10, 32'h3F00_0000, 1'b0}, 1'b0, none);
		add_row({3'd1, 16'd11, 32'hBF00_0000, 1'b1}, 1'b0, none);
		add_row({3'd0, 16'd40000, 32'h4200_0000, 1'b1}, 1'b0, none);
		add_row({3'd7, 16'd12, 32'h7F80_0001, 1'b1}, 1'b0, none);
		add_row({3'd0, 16'd13, 32'hFF80_0000, 1'b0}, 1'b0, none);
		add_row({3'd1, 16'd14, 32'hC200_0000, 1'b1}, 1'b0, none);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 8;
		stall_pct = 48;
		foreach (directed_rows[i])
			send_sample(directed_rows[i].s, directed_rows[i].fixed, directed_rows[i].want);
		drain();

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 48 : 0;
			stall_pct = (mode == 0) ? 48 : (mode == 1) ? 8 : 0;
			for (int phase = 0; phase < 4; phase++) begin
				c.detector_enable = ($urandom_range(0, 9) != 0);
				c.soft_jump_threshold = random_threshold();
				c.hard_jump_threshold = random_threshold();
				c.report_jump_threshold = random_threshold();
				c.crackle_min_jumps = ($urandom_range(0, 3) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, 8));
				c.crackle_jump_minimum = random_threshold();
				c.channels_in_use = ($urandom_range(0, 3) == 0) ? 4'($urandom)
					: 4'($urandom_range(1, MAX_CHANNELS));
				if (mode == 0 && phase == 0) begin
					c = {1'b1, 24'd0, 24'd0, 24'd0, 16'd0, 24'd0, 4'd1};
				end else if (mode == 1 && phase == 0) begin
					c = {1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 4'd8};
				end else if (mode == 1 && phase == 1) begin
					c.detector_enable = 1'b0;
				end else if (mode == 0 && phase == 1) begin
					c.channels_in_use = 4'd0;
				end else if (mode == 2 && phase == 0) begin
					c.detector_enable = 1'b1;
					c.channels_in_use = 4'd15;
				end
				apply_settings(c);
				stream_blocks(96);
				drain();
			end
		end

		if (mismatches == 0)
			$display("audio_glitch_detector_top_tb OK");
		else
			$display("audio_glitch_detector_top_tb NOT OK");
		$finish;
	end

endmodule

>>> files.f
rtl/core/agd_pkg.sv
rtl/core/agd_convert.sv
rtl/core/agd_track.sv
rtl/core/agd_classify.sv
rtl/core/audio_glitch_detector_top.sv
test/audio_glitch_detector_top_tb.sv
